### src/tess_pkg.sv
package tess_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 4;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [LEN_W-1:0]  len_t;

    // parser phase
    typedef enum logic [2:0]
    {
        PH_IDLE,
        PH_ESC,
        PH_ESC_INTER,
        PH_CSI_PARAM,
        PH_CSI_INTER,
        PH_SS3
    } phase_t;

    typedef enum logic [2:0]
    {
        KIND_SINGLE = 3'd0,
        KIND_ESC    = 3'd1,
        KIND_CSI    = 3'd2,
        KIND_SS3    = 3'd3,
        KIND_ABORT  = 3'd4
    } kind_t;

    typedef enum logic [2:0]
    {
        KEY_OTHER = 3'd0,
        KEY_SPACE = 3'd1,
        KEY_UP    = 3'd2,
        KEY_DOWN  = 3'd3,
        KEY_RIGHT = 3'd4,
        KEY_LEFT  = 3'd5
    } key_t;

    localparam byte_t ESC_CODE    = 8'h1B;
    localparam byte_t CSI_INTRO   = 8'h5B;  // '['
    localparam byte_t SS3_INTRO   = 8'h4F;  // 'O'
    localparam byte_t SPACE_CODE  = 8'h20;
    localparam byte_t INTER_LO    = 8'h20;
    localparam byte_t PARAM_LO    = 8'h30;
    localparam byte_t FINAL_LO    = 8'h40;
    localparam byte_t FINAL_END   = 8'h7F;
    localparam byte_t ARROW_UP    = 8'h41;  // 'A'
    localparam byte_t ARROW_DOWN  = 8'h42;  // 'B'
    localparam byte_t ARROW_RIGHT = 8'h43;  // 'C'
    localparam byte_t ARROW_LEFT  = 8'h44;  // 'D'

    // everything one input byte causes: an optional aborted escape, then an
    // optional finished sequence
    typedef struct packed
    {
        logic  abort_valid;
        len_t  abort_len;
        byte_t abort_end;
        logic  main_valid;
        len_t  main_len;
        kind_t main_kind;
        key_t  main_key;
        byte_t main_end;
    } rec_t;

endpackage

### src/tess_front.sv
module tess_front #(
    parameter int MAX_SEQ_BYTES = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  tess_pkg::byte_t  byte_in,
    output logic             rec_valid,
    output tess_pkg::rec_t   rec
);

    tess_pkg::phase_t phase_reg, phase_next;
    tess_pkg::len_t   cnt_reg, cnt_next;
    tess_pkg::byte_t  newest_reg, newest_next;

    logic             extend;
    logic             finish;
    logic             pending;
    tess_pkg::phase_t ext_phase;
    tess_pkg::kind_t  fin_kind;
    tess_pkg::key_t   fin_key;
    tess_pkg::key_t   arrow_key;
    logic             is_inter;
    logic             is_param;
    logic             is_final_esc;
    logic             is_final_csi;
    tess_pkg::len_t   grow_cnt;
    tess_pkg::len_t   fin_len;

    always_comb
    begin
        is_inter     = (byte_in >= tess_pkg::INTER_LO) && (byte_in < tess_pkg::PARAM_LO);
        is_param     = (byte_in >= tess_pkg::PARAM_LO) && (byte_in < tess_pkg::FINAL_LO);
        is_final_esc = (byte_in >= tess_pkg::PARAM_LO) && (byte_in < tess_pkg::FINAL_END);
        is_final_csi = (byte_in >= tess_pkg::FINAL_LO) && (byte_in < tess_pkg::FINAL_END);

        grow_cnt = (cnt_reg < tess_pkg::LEN_W'(MAX_SEQ_BYTES)) ?
                   cnt_reg + tess_pkg::LEN_W'(1) : tess_pkg::LEN_W'(MAX_SEQ_BYTES);
        fin_len  = (cnt_reg >= tess_pkg::LEN_W'(MAX_SEQ_BYTES - 1)) ?
                   tess_pkg::LEN_W'(MAX_SEQ_BYTES) : cnt_reg + tess_pkg::LEN_W'(1);

        case (byte_in)
            tess_pkg::ARROW_UP:    arrow_key = tess_pkg::KEY_UP;
            tess_pkg::ARROW_DOWN:  arrow_key = tess_pkg::KEY_DOWN;
            tess_pkg::ARROW_RIGHT: arrow_key = tess_pkg::KEY_RIGHT;
            tess_pkg::ARROW_LEFT:  arrow_key = tess_pkg::KEY_LEFT;
            default:               arrow_key = tess_pkg::KEY_OTHER;
        endcase

        extend    = 1'b0;
        finish    = 1'b0;
        pending   = 1'b0;
        ext_phase = phase_reg;
        fin_kind  = tess_pkg::KIND_ESC;
        fin_key   = tess_pkg::KEY_OTHER;

        unique case (phase_reg)
            tess_pkg::PH_ESC:
            begin
                pending = 1'b1;
                if (byte_in == tess_pkg::CSI_INTRO)
                begin
                    extend    = 1'b1;
                    ext_phase = tess_pkg::PH_CSI_PARAM;
                end
                else if (byte_in == tess_pkg::SS3_INTRO)
                begin
                    extend    = 1'b1;
                    ext_phase = tess_pkg::PH_SS3;
                end
                else if (is_inter)
                begin
                    extend    = 1'b1;
                    ext_phase = tess_pkg::PH_ESC_INTER;
                end
                else if (is_final_esc)
                begin
                    finish = 1'b1;
                end
            end
            tess_pkg::PH_ESC_INTER:
            begin
                pending = 1'b1;
                if (is_inter)
                    extend = 1'b1;
                else if (is_final_esc)
                    finish = 1'b1;
            end
            tess_pkg::PH_CSI_PARAM,
            tess_pkg::PH_CSI_INTER:
            begin
                pending = 1'b1;
                if ((phase_reg == tess_pkg::PH_CSI_PARAM) && is_param)
                begin
                    extend = 1'b1;
                end
                else if (is_inter)
                begin
                    extend    = 1'b1;
                    ext_phase = tess_pkg::PH_CSI_INTER;
                end
                else if (is_final_csi)
                begin
                    finish   = 1'b1;
                    fin_kind = tess_pkg::KIND_CSI;
                    // arrows only for exactly ESC '[' letter
                    if ((phase_reg == tess_pkg::PH_CSI_PARAM) &&
                        (cnt_reg == tess_pkg::LEN_W'(2)))
                        fin_key = arrow_key;
                end
            end
            tess_pkg::PH_SS3:
            begin
                pending = 1'b1;
                if (is_final_esc)
                begin
                    finish   = 1'b1;
                    fin_kind = tess_pkg::KIND_SS3;
                end
            end
            default:
            begin
                pending = 1'b0;
            end
        endcase

        rec             = '0;
        rec.main_kind   = tess_pkg::KIND_SINGLE;
        rec.main_key    = tess_pkg::KEY_OTHER;
        phase_next      = tess_pkg::PH_IDLE;
        cnt_next        = '0;
        newest_next     = '0;

        if (extend)
        begin
            phase_next  = ext_phase;
            cnt_next    = grow_cnt;
            newest_next = byte_in;
        end
        else if (finish)
        begin
            rec.main_valid = 1'b1;
            rec.main_len   = fin_len;
            rec.main_kind  = fin_kind;
            rec.main_key   = fin_key;
            rec.main_end   = byte_in;
        end
        else
        begin
            // breaking byte closes the escape, then starts afresh
            rec.abort_valid = pending;
            rec.abort_len   = cnt_reg;
            rec.abort_end   = newest_reg;
            if (byte_in == tess_pkg::ESC_CODE)
            begin
                phase_next  = tess_pkg::PH_ESC;
                cnt_next    = tess_pkg::LEN_W'(1);
                newest_next = byte_in;
            end
            else
            begin
                rec.main_valid = 1'b1;
                rec.main_len   = tess_pkg::LEN_W'(1);
                rec.main_kind  = tess_pkg::KIND_SINGLE;
                rec.main_key   = (byte_in == tess_pkg::SPACE_CODE) ?
                                 tess_pkg::KEY_SPACE : tess_pkg::KEY_OTHER;
                rec.main_end   = byte_in;
            end
        end

        rec_valid = take && (rec.abort_valid || rec.main_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= tess_pkg::PH_IDLE;
            cnt_reg    <= '0;
            newest_reg <= '0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            newest_reg <= newest_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= tess_pkg::LEN_W'(MAX_SEQ_BYTES))
        else $error("pending count beyond maximum");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == tess_pkg::PH_IDLE) |-> (cnt_reg == '0))
        else $error("idle parser holds a pending count");

endmodule

### src/tess_fifo.sv
module tess_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  tess_pkg::rec_t  wr_data,
    output logic            full,
    input  logic            rd_en,
    output logic            rd_valid,
    output tess_pkg::rec_t  rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tess_pkg::rec_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    always_comb
    begin
        full     = (count_reg == CNT_W'(DEPTH));
        rd_valid = (count_reg != '0);
        rd_data  = mem_reg[rd_ptr_reg];
        do_wr    = wr_en && !full;
        do_rd    = rd_en && rd_valid;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);

        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + CNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("record written into a full queue");

endmodule

### src/tess_back.sv
module tess_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  tess_pkg::rec_t  q_rec,
    output logic            q_pop,
    output logic            empty,
    input  logic            pop,
    output logic [3:0]      seq_length,
    output logic [2:0]      seq_kind,
    output logic [2:0]      key_code,
    output logic [7:0]      end_byte,
    output logic            last_of_run
);

    tess_pkg::rec_t rec_reg, rec_next;
    logic           valid_reg, valid_next;
    logic           half_reg, half_next;
    logic           show_abort;
    logic           taken;
    logic           done;

    always_comb
    begin
        show_abort = rec_reg.abort_valid && !half_reg;
        taken      = valid_reg && pop;
        done       = taken && !(show_abort && rec_reg.main_valid);
        q_pop      = q_valid && (!valid_reg || done);
        empty      = !valid_reg;

        if (show_abort)
        begin
            seq_length  = rec_reg.abort_len;
            seq_kind    = tess_pkg::KIND_ABORT;
            key_code    = tess_pkg::KEY_OTHER;
            end_byte    = rec_reg.abort_end;
            last_of_run = !rec_reg.main_valid;
        end
        else
        begin
            seq_length  = rec_reg.main_len;
            seq_kind    = rec_reg.main_kind;
            key_code    = rec_reg.main_key;
            end_byte    = rec_reg.main_end;
            last_of_run = 1'b1;
        end

        rec_next   = rec_reg;
        valid_next = valid_reg;
        half_next  = half_reg;
        if (q_pop)
        begin
            rec_next   = q_rec;
            valid_next = 1'b1;
            half_next  = 1'b0;
        end
        else if (done)
        begin
            valid_next = 1'b0;
            half_next  = 1'b0;
        end
        else if (taken)
        begin
            half_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    a_half_legal: assert property (@(posedge clk) disable iff (!rst_n)
        half_reg |-> (valid_reg && rec_reg.abort_valid && rec_reg.main_valid))
        else $error("second half flagged on a record without two results");

    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && pop && show_abort && rec_reg.main_valid) |=>
        (valid_reg && half_reg))
        else $error("main result lost after aborted escape");

endmodule

### src/terminal_escape_sequence_splitter.sv
// path: a byte's record is written into the record queue, then loaded into the output register
// throughput: one byte per cycle at the input while full is low, one result per cycle
//   at the output while pop is high; an escape-breaking byte's two results show in turn
// a four-deep record queue lets the parser run on while the result side is stalled
// reset (rst_n low, asynchronous) returns the parser to idle and empties queue and output
module terminal_escape_sequence_splitter #(
    parameter int MAX_SEQ_BYTES = 8,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    // input side, queue-like: push / full
    input  logic       push,
    output logic       full,
    input  logic [7:0] byte_in,
    // result side, queue-like: empty / pop
    output logic       empty,
    input  logic       pop,
    output logic [3:0] seq_length,
    output logic [2:0] seq_kind,
    output logic [2:0] key_code,
    output logic [7:0] end_byte,
    output logic       last_of_run
);

    // a transaction on the input side happens when push is high and full low
    logic           take;
    logic           rec_valid;
    tess_pkg::rec_t rec;
    logic           q_valid;
    logic           q_pop;
    tess_pkg::rec_t q_rec;

    assign take = push && !full;

    // front: escape parser, one byte per cycle while full is low, emits one record per byte
    // that yields any result (a pure extension of an escape yields none)
    tess_front #(
        .MAX_SEQ_BYTES (MAX_SEQ_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .byte_in   (byte_in),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    // queue between parser and result side; full stalls the input side
    tess_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (rec_valid),
        .wr_data  (rec),
        .full     (full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_rec)
    );

    // back: output register, splits a record into its one or two results
    tess_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_rec       (q_rec),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .seq_length  (seq_length),
        .seq_kind    (seq_kind),
        .key_code    (key_code),
        .end_byte    (end_byte),
        .last_of_run (last_of_run)
    );

endmodule

### bench/tb_terminal_escape_sequence_splitter.sv
module tb_terminal_escape_sequence_splitter;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEQ_MAX     = 8;
    localparam int DIRECTED_N  = 25;
    localparam int RANDOM_N    = 1450;
    localparam int CYCLE_LIMIT = 200000;
    // pause points of the input side: wait there until every sequence has been read back
    localparam int MID_PAUSE   = 800;
    localparam int SETTLE_CYCLES = 20;

    // one finished sequence as the result side shows it
    typedef struct packed
    {
        tess_pkg::len_t  len;
        tess_pkg::kind_t kind;
        tess_pkg::key_t  key;
        tess_pkg::byte_t endb;
        logic            last;
    } seq_res_t;

    // one input byte; a typed-in sequence replaces the prediction where fixed is set
    typedef struct packed
    {
        tess_pkg::byte_t code;
        logic            fixed;
        seq_res_t        want;
    } row_t;

    localparam seq_res_t NO_RES = '0;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] byte_in = 8'h00;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [3:0] seq_length;
    logic [2:0] seq_kind;
    logic [2:0] key_code;
    logic [7:0] end_byte;
    logic       last_of_run;

    terminal_escape_sequence_splitter #(
        .MAX_SEQ_BYTES(SEQ_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .byte_in(byte_in),
        .empty(empty),
        .pop(pop),
        .seq_length(seq_length),
        .seq_kind(seq_kind),
        .key_code(key_code),
        .end_byte(end_byte),
        .last_of_run(last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // directed bytes: extremes of the byte, space, the up and left arrow ends, an SS3 key,
    // aborts by a high byte, by a second ESC and by a null inside SS3, and a
    // CSI with parameter and intermediate
    row_t directed_rows [DIRECTED_N] = '{
        '{8'h00, 1'b1,
          '{4'd1, tess_pkg::KIND_SINGLE, tess_pkg::KEY_OTHER, 8'h00, 1'b1}},
        '{8'hFF, 1'b1,
          '{4'd1, tess_pkg::KIND_SINGLE, tess_pkg::KEY_OTHER, 8'hFF, 1'b1}},
        '{tess_pkg::SPACE_CODE, 1'b1,
          '{4'd1, tess_pkg::KIND_SINGLE, tess_pkg::KEY_SPACE, tess_pkg::SPACE_CODE, 1'b1}},
        '{tess_pkg::ESC_CODE, 1'b0, NO_RES},
        '{tess_pkg::CSI_INTRO, 1'b0, NO_RES},
        '{tess_pkg::ARROW_UP, 1'b1,
          '{4'd3, tess_pkg::KIND_CSI, tess_pkg::KEY_UP, tess_pkg::ARROW_UP, 1'b1}},
        '{tess_pkg::ESC_CODE, 1'b0, NO_RES},
        '{tess_pkg::CSI_INTRO, 1'b0, NO_RES},
        '{tess_pkg::ARROW_LEFT, 1'b1,
          '{4'd3, tess_pkg::KIND_CSI, tess_pkg::KEY_LEFT, tess_pkg::ARROW_LEFT, 1'b1}},
        '{tess_pkg::ESC_CODE, 1'b0, NO_RES},
        '{tess_pkg::SS3_INTRO, 1'b0, NO_RES},
        '{8'h50, 1'b0, NO_RES},
        '{tess_pkg::ESC_CODE, 1'b0, NO_RES},
        '{8'h80, 1'b0, NO_RES},
        '{tess_pkg::ESC_CODE, 1'b0, NO_RES},
        '{tess_pkg::ESC_CODE, 1'b0, NO_RES},
        '{8'h63, 1'b0, NO_RES},
        '{tess_pkg::ESC_CODE, 1'b0, NO_RES},
        '{tess_pkg::CSI_INTRO, 1'b0, NO_RES},
        '{8'h31, 1'b0, NO_RES},
        '{8'h20, 1'b0, NO_RES},
        '{8'h7E, 1'b0, NO_RES},
        '{tess_pkg::ESC_CODE, 1'b0, NO_RES},
        '{tess_pkg::SS3_INTRO, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES}
    };

    row_t     stim[$];
    seq_res_t seq_due[$];   // sequences still to be read back, oldest first
    seq_res_t fresh[$];     // sequences caused by the byte just split

    // shadow of the parser state
    tess_pkg::phase_t shadow_phase = tess_pkg::PH_IDLE;
    int               shadow_count = 0;
    tess_pkg::byte_t  shadow_newest = 8'h00;

    int sent = 0;
    int cycle_count = 0;
    int fail_count = 0;

    function automatic bit in_span(tess_pkg::byte_t b, tess_pkg::byte_t lo,
                                   tess_pkg::byte_t hi_excl);
        return (b >= lo) && (b < hi_excl);
    endfunction

    function automatic tess_pkg::len_t closed_len();
        int n;
        n = shadow_count + 1;
        return tess_pkg::len_t'((n > SEQ_MAX) ? SEQ_MAX : n);
    endfunction

    function automatic void clear_shadow();
        shadow_phase = tess_pkg::PH_IDLE;
        shadow_count = 0;
        shadow_newest = 8'h00;
    endfunction

    // splits one byte: updates the shadow state, leaves new sequences in fresh
    function automatic void split_byte(tess_pkg::byte_t b);
        tess_pkg::phase_t ph;
        logic             extend;
        logic             finish;
        tess_pkg::kind_t  kind;
        tess_pkg::key_t   key;
        seq_res_t         r;
        ph = shadow_phase;
        extend = 1'b0;
        finish = 1'b0;
        kind = tess_pkg::KIND_ESC;
        key = tess_pkg::KEY_OTHER;
        fresh.delete();
        case (ph)
            tess_pkg::PH_ESC:
            begin
                if (b == tess_pkg::CSI_INTRO)
                begin
                    shadow_phase = tess_pkg::PH_CSI_PARAM;
                    extend = 1'b1;
                end
                else if (b == tess_pkg::SS3_INTRO)
                begin
                    shadow_phase = tess_pkg::PH_SS3;
                    extend = 1'b1;
                end
                else if (in_span(b, tess_pkg::INTER_LO, tess_pkg::PARAM_LO))
                begin
                    shadow_phase = tess_pkg::PH_ESC_INTER;
                    extend = 1'b1;
                end
                else if (in_span(b, tess_pkg::PARAM_LO, tess_pkg::FINAL_END))
                    finish = 1'b1;
            end
            tess_pkg::PH_ESC_INTER:
            begin
                if (in_span(b, tess_pkg::INTER_LO, tess_pkg::PARAM_LO))
                    extend = 1'b1;
                else if (in_span(b, tess_pkg::PARAM_LO, tess_pkg::FINAL_END))
                    finish = 1'b1;
            end
            tess_pkg::PH_CSI_PARAM, tess_pkg::PH_CSI_INTER:
            begin
                if (ph == tess_pkg::PH_CSI_PARAM &&
                    in_span(b, tess_pkg::PARAM_LO, tess_pkg::FINAL_LO))
                    extend = 1'b1;
                else if (in_span(b, tess_pkg::INTER_LO, tess_pkg::PARAM_LO))
                begin
                    shadow_phase = tess_pkg::PH_CSI_INTER;
                    extend = 1'b1;
                end
                else if (in_span(b, tess_pkg::FINAL_LO, tess_pkg::FINAL_END))
                begin
                    finish = 1'b1;
                    kind = tess_pkg::KIND_CSI;
                    // arrows only as the bare three-byte form
                    if (ph == tess_pkg::PH_CSI_PARAM && shadow_count == 2)
                    begin
                        case (b)
                            tess_pkg::ARROW_UP:    key = tess_pkg::KEY_UP;
                            tess_pkg::ARROW_DOWN:  key = tess_pkg::KEY_DOWN;
                            tess_pkg::ARROW_RIGHT: key = tess_pkg::KEY_RIGHT;
                            tess_pkg::ARROW_LEFT:  key = tess_pkg::KEY_LEFT;
                            default:               key = tess_pkg::KEY_OTHER;
                        endcase
                    end
                end
            end
            tess_pkg::PH_SS3:
            begin
                if (in_span(b, tess_pkg::PARAM_LO, tess_pkg::FINAL_END))
                begin
                    finish = 1'b1;
                    kind = tess_pkg::KIND_SS3;
                end
            end
            default:
                ph = tess_pkg::PH_IDLE;
        endcase

        if (extend)
        begin
            // length saturates, the newest byte is always kept
            if (shadow_count < SEQ_MAX)
                shadow_count = shadow_count + 1;
            shadow_newest = b;
            return;
        end
        if (finish)
        begin
            r = '{closed_len(), kind, key, b, 1'b1};
            fresh.push_back(r);
            clear_shadow();
            return;
        end
        if (ph != tess_pkg::PH_IDLE)
        begin
            // the byte cannot continue the escape: close it as aborted
            r = '{tess_pkg::len_t'(shadow_count), tess_pkg::KIND_ABORT, tess_pkg::KEY_OTHER,
                  shadow_newest, 1'b0};
            fresh.push_back(r);
            clear_shadow();
        end
        if (b == tess_pkg::ESC_CODE)
        begin
            shadow_phase = tess_pkg::PH_ESC;
            shadow_count = 1;
            shadow_newest = b;
            if (fresh.size() > 0)
                fresh[0].last = 1'b1;
            return;
        end
        r = '{4'd1, tess_pkg::KIND_SINGLE,
              (b == tess_pkg::SPACE_CODE) ? tess_pkg::KEY_SPACE : tess_pkg::KEY_OTHER,
              b, 1'b1};
        fresh.push_back(r);
    endfunction

    task automatic add_byte(input tess_pkg::byte_t b);
        row_t r;
        r.code = b;
        r.fixed = 1'b0;
        r.want = NO_RES;
        stim.push_back(r);
    endtask

    task automatic add_span(input int n, input int lo, input int hi);
        for (int i = 0; i < n; i++)
            add_byte(tess_pkg::byte_t'($urandom_range(hi, lo)));
    endtask

    // one random burst: mostly well-formed sequences, the rest broken ones and noise
    task automatic add_burst();
        int roll;
        int n;
        roll = $urandom_range(99);
        if (roll < 12)
        begin
            // bare arrow key
            add_byte(tess_pkg::ESC_CODE);
            add_byte(tess_pkg::CSI_INTRO);
            add_byte(tess_pkg::byte_t'(tess_pkg::ARROW_UP + $urandom_range(3)));
        end
        else if (roll < 32)
        begin
            // CSI, now and then long enough to saturate the length
            add_byte(tess_pkg::ESC_CODE);
            add_byte(tess_pkg::CSI_INTRO);
            n = ($urandom_range(15) == 0) ? $urandom_range(12, 6) : $urandom_range(3);
            add_span(n, 8'h30, 8'h3F);
            n = ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0;
            add_span(n, 8'h20, 8'h2F);
            add_span(1, 8'h40, 8'h7E);
        end
        else if (roll < 45)
        begin
            add_byte(tess_pkg::ESC_CODE);
            n = ($urandom_range(20) == 0) ? $urandom_range(10, 7) : $urandom_range(3);
            add_span(n, 8'h20, 8'h2F);
            add_span(1, 8'h30, 8'h7E);
        end
        else if (roll < 55)
        begin
            add_byte(tess_pkg::ESC_CODE);
            add_byte(tess_pkg::SS3_INTRO);
            add_span(1, 8'h30, 8'h7E);
        end
        else if (roll < 72)
            add_span($urandom_range(3, 1), 8'h00, 8'hFF);
        else if (roll < 90)
        begin
            // escape broken off by an arbitrary byte
            add_byte(tess_pkg::ESC_CODE);
            case ($urandom_range(4))
                0: ;
                1:
                begin
                    add_byte(tess_pkg::CSI_INTRO);
                    add_span($urandom_range(4), 8'h30, 8'h3F);
                end
                2:
                begin
                    // a parameter byte after an intermediate also breaks it
                    add_byte(tess_pkg::CSI_INTRO);
                    add_span($urandom_range(2, 1), 8'h20, 8'h2F);
                    add_span(1, 8'h30, 8'h3F);
                end
                3: add_byte(tess_pkg::SS3_INTRO);
                default: add_span($urandom_range(3, 1), 8'h20, 8'h2F);
            endcase
            add_span(1, 8'h00, 8'hFF);
        end
        else
        begin
            n = $urandom_range(4, 1);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(2))
                    0: add_byte(tess_pkg::ESC_CODE);
                    1: add_span(1, 8'h20, 8'h7E);
                    default: add_span(1, 8'h00, 8'hFF);
                endcase
            end
        end
    endtask

    // single clocked process: read back results, take in the byte transaction,
    // then set up the next edge; all in one place so the edge order cannot matter
    always @(posedge clk)
    begin
        logic calm;
        logic hold;
        seq_res_t got;
        seq_res_t exp_res;
        cycle_count <= cycle_count + 1;
        if (rst_n)
        begin
            // result side transaction
            if (pop && !empty)
            begin
                got = '{seq_length, tess_pkg::kind_t'(seq_kind), tess_pkg::key_t'(key_code),
                        end_byte, last_of_run};
                if (seq_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected sequence: len=%0d kind=%0d key=%0d %s%02h %s%0d",
                                 got.len, got.kind, got.key, "end=", got.endb, "last=",
                                 got.last);
                end
                else
                begin
                    exp_res = seq_due.pop_front();
                    if (got.len !== exp_res.len || got.kind !== exp_res.kind
                        || got.key !== exp_res.key || got.endb !== exp_res.endb
                        || got.last !== exp_res.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("mismatch exp len=%0d kind=%0d key=%0d end=%02h last=%0d",
                                     exp_res.len, exp_res.kind, exp_res.key, exp_res.endb,
                                     exp_res.last);
                            $display("         got len=%0d kind=%0d key=%0d end=%02h last=%0d",
                                     got.len, got.kind, got.key, got.endb, got.last);
                        end
                    end
                end
            end

            // input side transaction
            if (push && !full)
            begin
                split_byte(stim[sent].code);
                if (stim[sent].fixed)
                    seq_due.push_back(stim[sent].want);
                else
                    foreach (fresh[i])
                        seq_due.push_back(fresh[i]);
                sent++;
            end

            // no idling on either side in this stretch
            calm = (sent >= 400) && (sent < 650);
            // drain pause after the directed bytes and once in the middle
            hold = (sent == DIRECTED_N || sent == MID_PAUSE) && (seq_due.size() != 0);

            if (sent < stim.size() && !hold && (calm || $urandom_range(99) >= 22))
            begin
                push <= 1'b1;
                byte_in <= stim[sent].code;
            end
            else
                push <= 1'b0;
            pop <= calm || ($urandom_range(99) >= 22);
        end
    end

    initial
    begin
        foreach (directed_rows[i])
            stim.push_back(directed_rows[i]);
        while (stim.size() < DIRECTED_N + RANDOM_N)
            add_burst();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (sent < stim.size() || seq_due.size() != 0)
            @(posedge clk);
        // let any stray sequence surface before judging
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && seq_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
